### src/pjh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pjh_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_BEACON = 2'd2,
    OP_MSG    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MSG_JOIN_REQ   = 2'd0,
    MSG_ACCEPT     = 2'd1,
    MSG_REJECT     = 2'd2,
    MSG_GAP_CHANGE = 2'd3
  } msg_e;

  typedef enum logic [2:0] {
    ACT_JOIN_REQ  = 3'd0,
    ACT_ACCEPT    = 3'd1,
    ACT_REJECT    = 3'd2,
    ACT_GAP_BCAST = 3'd3,
    ACT_LEADER    = 3'd4,
    ACT_MEMBER    = 3'd5,
    ACT_APPLY_GAP = 3'd6
  } act_e;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_MAX_SIZE   = 3'd1,
    CFG_WAIT_BCN   = 3'd2,
    CFG_WAIT_REPLY = 3'd3,
    CFG_OWN_ID     = 3'd4
  } cfg_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned IdW      = 16;
  localparam int unsigned DepthW   = 8;
  localparam int unsigned GapW     = 10;
  localparam int unsigned ShadeW   = 8;
  localparam int unsigned TimerW   = 16;

  localparam logic [GapW-1:0]   GAP_LEADER   = 10'd350;
  localparam logic [GapW-1:0]   GAP_MEMBER   = 10'd55;
  localparam logic [GapW-1:0]   GAP_WIDE     = 10'd60;
  localparam logic [IdW-1:0]    BROADCAST_ID = 16'hFFFF;
  localparam logic [ShadeW-1:0] SHADE_FULL   = 8'd255;
  localparam logic [DepthW-1:0] DEPTH_MAX    = 8'd255;
  localparam logic [7:0]        SIZE_MIN     = 8'd3;
  localparam logic [7:0]        SIZE_OFFSET  = 8'd2;

  localparam logic [7:0]        RST_MAX_SIZE = 8'd8;
  localparam logic [TimerW-1:0] RST_WAIT     = 16'd100;

  localparam int unsigned DivSteps = 8;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic capture;
    logic commit;
    logic mul;
    logic sat;
    logic sel;
  } dp_cmd_t;

  typedef struct packed {
    logic has_res;
    logic two_res;
    logic need_shade;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    act_e              action;
    logic [IdW-1:0]    dest_id;
    logic [IdW-1:0]    platoon_id;
    logic [DepthW-1:0] depth;
    logic [GapW-1:0]   gap;
    logic [ShadeW-1:0] shade;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

### src/pjh_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pjh_div (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [7:0] divisor_i,
  output logic            done_o,
  output logic [7:0]      quot_o
);

  logic [7:0] rem_q, rem_d;
  logic [7:0] quo_q, quo_d;
  logic [7:0] dsr_q;
  logic [pjh_pkg::DivCntW-1:0] cnt_q;
  logic busy_q, done_q;
  logic [8:0] trial, diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[7]};
    diff  = trial - {1'b0, dsr_q};
    if (!diff[8]) begin
      rem_d = diff[7:0];
      quo_d = {quo_q[6:0], 1'b1};
    end else begin
      rem_d = trial[7:0];
      quo_d = {quo_q[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == pjh_pkg::DivCntW'(pjh_pkg::DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= pjh_pkg::SHADE_FULL;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

### src/pjh_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pjh_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pjh_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [pjh_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic [1:0]                       operation_i,
  input  wire logic                             has_leader_i,
  input  wire logic [1:0]                       msg_type_i,
  input  wire logic [pjh_pkg::IdW-1:0]          sender_id_i,
  input  wire logic [pjh_pkg::IdW-1:0]          msg_platoon_id_i,
  input  wire logic [pjh_pkg::DepthW-1:0]       msg_depth_i,
  input  wire logic [pjh_pkg::GapW-1:0]         msg_gap_i,
  input  wire pjh_pkg::dp_cmd_t                 cmd_i,
  output pjh_pkg::dp_stat_t                     stat_o,
  output pjh_pkg::result_t                      res_o
);

  typedef enum logic [2:0] {
    ROLE_IDLE        = 3'd0,
    ROLE_WAIT_BEACON = 3'd1,
    ROLE_ASK_JOIN    = 3'd2,
    ROLE_LEADER      = 3'd3,
    ROLE_MEMBER      = 3'd4
  } role_e;

  // configuration
  logic                         en_q;
  logic [7:0]                   max_q;
  logic [pjh_pkg::TimerW-1:0]   wbt_q, wrt_q;
  logic [pjh_pkg::IdW-1:0]      own_q;

  // captured item
  pjh_pkg::op_e                 it_op_q;
  logic                         it_hl_q;
  pjh_pkg::msg_e                it_mt_q;
  logic [pjh_pkg::IdW-1:0]      it_snd_q, it_pid_q;
  logic [pjh_pkg::DepthW-1:0]   it_dep_q;
  logic [pjh_pkg::GapW-1:0]     it_gap_q;

  // vehicle state
  role_e                        role_q, role_d;
  logic [pjh_pkg::TimerW-1:0]   tcnt_q, tcnt_d;
  logic                         trun_q, trun_d;
  logic [pjh_pkg::IdW-1:0]      plat_q, plat_d;
  logic                         inp_q, inp_d;
  logic [pjh_pkg::DepthW-1:0]   dep_q, dep_d;
  logic [7:0]                   mem_q, mem_d;
  logic [pjh_pkg::IdW-1:0]      lp_q, lp_d;
  logic [pjh_pkg::DepthW-1:0]   ld_q, ld_d;

  pjh_pkg::result_t             res0_q, res1_q, r0, r1;
  logic                         has_r, two_r, go_leader, go_member;
  logic [7:0]                   mem_inc;
  logic [15:0]                  prod_q;
  logic [7:0]                   quot, step;
  logic                         div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      max_q <= pjh_pkg::RST_MAX_SIZE;
      wbt_q <= pjh_pkg::RST_WAIT;
      wrt_q <= pjh_pkg::RST_WAIT;
      own_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pjh_pkg::CFG_ENABLE:     en_q  <= cfg_data_i[0];
        pjh_pkg::CFG_MAX_SIZE:   max_q <= cfg_data_i[7:0];
        pjh_pkg::CFG_WAIT_BCN:   wbt_q <= cfg_data_i;
        pjh_pkg::CFG_WAIT_REPLY: wrt_q <= cfg_data_i;
        pjh_pkg::CFG_OWN_ID:     own_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      it_op_q  <= pjh_pkg::op_e'(operation_i);
      it_hl_q  <= has_leader_i;
      it_mt_q  <= pjh_pkg::msg_e'(msg_type_i);
      it_snd_q <= sender_id_i;
      it_pid_q <= msg_platoon_id_i;
      it_dep_q <= msg_depth_i;
      it_gap_q <= msg_gap_i;
    end
  end

  assign mem_inc = mem_q + 8'd1;

  always_comb begin
    role_d    = role_q;
    tcnt_d    = tcnt_q;
    trun_d    = trun_q;
    plat_d    = plat_q;
    inp_d     = inp_q;
    dep_d     = dep_q;
    mem_d     = mem_q;
    lp_d      = lp_q;
    ld_d      = ld_q;
    has_r     = 1'b0;
    two_r     = 1'b0;
    go_leader = 1'b0;
    go_member = 1'b0;
    r0        = '0;
    r1            = '0;
    r1.action     = pjh_pkg::ACT_GAP_BCAST;
    r1.dest_id    = pjh_pkg::BROADCAST_ID;
    r1.platoon_id = plat_q;
    r1.depth      = dep_q;
    r1.gap        = pjh_pkg::GAP_WIDE;
    r1.last       = 1'b1;
    if (en_q) begin
      unique case (it_op_q)
        pjh_pkg::OP_START: begin
          if (role_q == ROLE_IDLE) begin
            if (!it_hl_q) begin
              go_leader = 1'b1;
            end else begin
              role_d = ROLE_WAIT_BEACON;
              tcnt_d = wbt_q;
              trun_d = 1'b1;
            end
          end
        end
        pjh_pkg::OP_TICK: begin
          if (trun_q) begin
            if (tcnt_q <= 16'd1) begin
              tcnt_d = '0;
              trun_d = 1'b0;
              if (role_q == ROLE_WAIT_BEACON || role_q == ROLE_ASK_JOIN) begin
                go_leader = 1'b1;
              end
            end else begin
              tcnt_d = tcnt_q - 16'd1;
            end
          end
        end
        pjh_pkg::OP_BEACON: begin
          if (role_q == ROLE_WAIT_BEACON && trun_q) begin
            role_d        = ROLE_ASK_JOIN;
            lp_d          = it_pid_q;
            ld_d          = it_dep_q;
            tcnt_d        = wrt_q;
            trun_d        = 1'b1;
            has_r         = 1'b1;
            r0.action     = pjh_pkg::ACT_JOIN_REQ;
            r0.dest_id    = it_snd_q;
            r0.platoon_id = it_pid_q;
          end
        end
        pjh_pkg::OP_MSG: begin
          unique case (it_mt_q)
            pjh_pkg::MSG_REJECT: begin
              if (role_q == ROLE_ASK_JOIN) go_leader = 1'b1;
            end
            pjh_pkg::MSG_ACCEPT: begin
              if (role_q == ROLE_ASK_JOIN) go_member = 1'b1;
            end
            pjh_pkg::MSG_JOIN_REQ: begin
              if (role_q == ROLE_LEADER) begin
                has_r         = 1'b1;
                r0.dest_id    = it_snd_q;
                r0.platoon_id = it_pid_q;
                r0.depth      = dep_q;
                if (mem_q >= max_q) begin
                  r0.action = pjh_pkg::ACT_REJECT;
                end else begin
                  r0.action = pjh_pkg::ACT_ACCEPT;
                  mem_d     = mem_inc;
                  two_r     = (mem_inc > (max_q >> 1));
                end
              end
            end
            pjh_pkg::MSG_GAP_CHANGE: begin
              if (inp_q && it_pid_q == plat_q) begin
                has_r         = 1'b1;
                r0.action     = pjh_pkg::ACT_APPLY_GAP;
                r0.platoon_id = plat_q;
                r0.depth      = dep_q;
                r0.gap        = it_gap_q;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (go_leader) begin
      role_d        = ROLE_LEADER;
      trun_d        = 1'b0;
      tcnt_d        = '0;
      plat_d        = own_q;
      inp_d         = 1'b1;
      dep_d         = '0;
      mem_d         = 8'd1;
      has_r         = 1'b1;
      r0            = '0;
      r0.action     = pjh_pkg::ACT_LEADER;
      r0.platoon_id = own_q;
      r0.gap        = pjh_pkg::GAP_LEADER;
    end
    if (go_member) begin
      role_d        = ROLE_MEMBER;
      trun_d        = 1'b0;
      tcnt_d        = '0;
      plat_d        = lp_q;
      inp_d         = 1'b1;
      dep_d         = (ld_q == pjh_pkg::DEPTH_MAX) ? pjh_pkg::DEPTH_MAX : ld_q + 8'd1;
      has_r         = 1'b1;
      r0            = '0;
      r0.action     = pjh_pkg::ACT_MEMBER;
      r0.platoon_id = lp_q;
      r0.depth      = dep_d;
      r0.gap        = pjh_pkg::GAP_MEMBER;
    end
    r0.last = !two_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q <= ROLE_IDLE;
      tcnt_q <= '0;
      trun_q <= 1'b0;
      plat_q <= '0;
      inp_q  <= 1'b0;
      dep_q  <= '0;
      mem_q  <= '0;
      lp_q   <= '0;
      ld_q   <= '0;
    end else if (cmd_i.commit) begin
      role_q <= role_d;
      tcnt_q <= tcnt_d;
      trun_q <= trun_d;
      plat_q <= plat_d;
      inp_q  <= inp_d;
      dep_q  <= dep_d;
      mem_q  <= mem_d;
      lp_q   <= lp_d;
      ld_q   <= ld_d;
    end
  end

  // shade step 255 / (max - 2)
  pjh_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.commit && go_member),
    .divisor_i (max_q - pjh_pkg::SIZE_OFFSET),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign step = (max_q < pjh_pkg::SIZE_MIN) ? pjh_pkg::SHADE_FULL : quot;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= {8'd0, dep_q - 8'd1} * {8'd0, step};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res0_q <= r0;
      res1_q <= r1;
    end else if (cmd_i.sat) begin
      res0_q.shade <= (|prod_q[15:8]) ? pjh_pkg::SHADE_FULL : prod_q[7:0];
    end
  end

  assign stat_o.has_res    = has_r;
  assign stat_o.two_res    = !res0_q.last;
  assign stat_o.need_shade = go_member;
  assign stat_o.div_done   = div_done;

  assign res_o = cmd_i.sel ? res1_q : res0_q;

endmodule

`default_nettype wire

### src/pjh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pjh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire pjh_pkg::dp_stat_t stat_i,
  output pjh_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EVAL = 3'd1,
    S_DIV  = 3'd2,
    S_MUL  = 3'd3,
    S_SAT  = 3'd4,
    S_OUT0 = 3'd5,
    S_OUT1 = 3'd6
  } state_e;

  state_e state_q;
  logic   in_stall_q, out_valid_q, sel_q;
  logic   accept;

  assign accept = (state_q == S_IDLE) && in_valid_i && !in_stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q    <= S_EVAL;
            in_stall_q <= 1'b1;
          end
        end
        S_EVAL: begin
          if (!stat_i.has_res) begin
            state_q    <= S_IDLE;
            in_stall_q <= 1'b0;
          end else if (stat_i.need_shade) begin
            state_q <= S_DIV;
          end else begin
            state_q     <= S_OUT0;
            out_valid_q <= 1'b1;
            sel_q       <= 1'b0;
          end
        end
        S_DIV: begin
          if (stat_i.div_done) state_q <= S_MUL;
        end
        S_MUL: state_q <= S_SAT;
        S_SAT: begin
          state_q     <= S_OUT0;
          out_valid_q <= 1'b1;
          sel_q       <= 1'b0;
        end
        S_OUT0: begin
          if (!out_stall_i) begin
            if (stat_i.two_res) begin
              state_q <= S_OUT1;
              sel_q   <= 1'b1;
            end else begin
              state_q     <= S_IDLE;
              out_valid_q <= 1'b0;
              in_stall_q  <= 1'b0;
            end
          end
        end
        S_OUT1: begin
          if (!out_stall_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_stall_q  <= 1'b0;
            sel_q       <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_o.capture = accept;
  assign cmd_o.commit  = (state_q == S_EVAL);
  assign cmd_o.mul     = (state_q == S_MUL);
  assign cmd_o.sat     = (state_q == S_SAT);
  assign cmd_o.sel     = sel_q;

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### src/platoon_join_handshake_fsm.sv
// an item without result returns to idle after evaluation; with results the first is shown
// once the item has been evaluated, the second follows once the first is taken
// becoming a member adds the 8-step shade divider and the multiply
// flow: one item at a time; the input stays stalled until the item's results are all taken
// reset: asynchronous active low, config, control and state registers reset, vehicle idle
`timescale 1ns / 1ps
`default_nettype none

module platoon_join_handshake_fsm (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pjh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [pjh_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic                          has_leader_i,
  input  wire logic [1:0]                    msg_type_i,
  input  wire logic [pjh_pkg::IdW-1:0]       sender_id_i,
  input  wire logic [pjh_pkg::IdW-1:0]       msg_platoon_id_i,
  input  wire logic [pjh_pkg::DepthW-1:0]    msg_depth_i,
  input  wire logic [pjh_pkg::GapW-1:0]      msg_gap_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         action_o,
  output logic [pjh_pkg::IdW-1:0]            dest_id_o,
  output logic [pjh_pkg::IdW-1:0]            platoon_id_o,
  output logic [pjh_pkg::DepthW-1:0]         depth_o,
  output logic [pjh_pkg::GapW-1:0]           gap_o,
  output logic [pjh_pkg::ShadeW-1:0]         shade_o,
  output logic                               last_o
);

  pjh_pkg::dp_cmd_t  cmd;
  pjh_pkg::dp_stat_t stat;
  pjh_pkg::result_t  res;

  pjh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pjh_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .has_leader_i     (has_leader_i),
    .msg_type_i       (msg_type_i),
    .sender_id_i      (sender_id_i),
    .msg_platoon_id_i (msg_platoon_id_i),
    .msg_depth_i      (msg_depth_i),
    .msg_gap_i        (msg_gap_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .res_o            (res)
  );

  assign action_o     = res.action;
  assign dest_id_o    = res.dest_id;
  assign platoon_id_o = res.platoon_id;
  assign depth_o      = res.depth;
  assign gap_o        = res.gap;
  assign shade_o      = res.shade;
  assign last_o       = res.last;

endmodule

`default_nettype wire

### src/pjh_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pjh_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [2:0]                   action_o,
  input wire logic [pjh_pkg::IdW-1:0]      dest_id_o,
  input wire logic [pjh_pkg::IdW-1:0]      platoon_id_o,
  input wire logic [pjh_pkg::DepthW-1:0]   depth_o,
  input wire logic [pjh_pkg::GapW-1:0]     gap_o,
  input wire logic [pjh_pkg::ShadeW-1:0]   shade_o,
  input wire logic                         last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) && $stable(dest_id_o)
      && $stable(platoon_id_o) && $stable(depth_o) && $stable(gap_o)
      && $stable(shade_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("block not busy after taking an item");

  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> action_o == pjh_pkg::ACT_ACCEPT)
    else $error("non-final result is not an accept");

  a_second_bcast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && last_o && action_o == pjh_pkg::ACT_GAP_BCAST)
    else $error("gap broadcast does not follow accept");

endmodule

bind platoon_join_handshake_fsm pjh_checker u_pjh_checker (.*);

`default_nettype wire
